// File: hdl/atr_pkg.sv
// Shared types, widths and constants for the averaged tilt/roll angle block.
// Holds the CORDIC arctangent table. Used by every module under hdl/.
package atr_pkg;

    // Field widths
    localparam int ADC_BITS    = 10;
    localparam int MAX_SAMPLES = 64;
    localparam int SUM_W       = 16;
    localparam int CNT_W       = 7;
    localparam int ZG_W        = 10;
    localparam int ANG_W       = 16;

    // Datapath widths: offset-corrected sums, CORDIC x/y and angle accumulator
    localparam int OFS_W       = 18;
    localparam int CW          = 28;
    localparam int ZW          = 26;

    // Angle constants (Q7 output, Q16 internal)
    localparam int DEG180_Q7   = 23040;
    localparam int DEG90_Q7    = 11520;
    localparam int DEG90_Q16   = 5898240;
    localparam int PRE_SHIFT   = 8;
    localparam int RND_BIAS    = 256;
    localparam int RND_SHIFT   = 9;

    // Configuration port
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_COUNT = 2'd0,
        REG_ZERO_G_Y     = 2'd1,
        REG_ZERO_G_Z     = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [ADC_BITS-1:0] adc_x;
        logic [ADC_BITS-1:0] adc_y;
        logic [ADC_BITS-1:0] adc_z;
    } sample_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum_x;
        logic [SUM_W-1:0] sum_y;
        logic [SUM_W-1:0] sum_z;
        logic [ANG_W-1:0] roll_angle;
    } result_t;

    // Closed window handed from the lanes to the merging stage
    typedef struct packed {
        logic [SUM_W-1:0] sum_x;
        logic [SUM_W-1:0] sum_y;
        logic [SUM_W-1:0] sum_z;
        logic [CNT_W-1:0] n;
    } window_t;

    // One item travelling down the CORDIC chain
    typedef struct packed {
        logic [SUM_W-1:0] sum_x;
        logic [SUM_W-1:0] sum_y;
        logic [SUM_W-1:0] sum_z;
        logic [CW-1:0]    x;
        logic [CW-1:0]    y;
        logic [ZW-1:0]    z;
        logic             spec;
        logic [ANG_W-1:0] spec_ang;
    } pipe_t;

    // atan(2^-i) in degrees, 16 fraction bits
    function automatic logic [ZW-1:0] atan_q16(input int unsigned idx);
        logic [ZW-1:0] v;
        case (idx)
            0:       v = ZW'(2949120);
            1:       v = ZW'(1740967);
            2:       v = ZW'(919879);
            3:       v = ZW'(466945);
            4:       v = ZW'(234379);
            5:       v = ZW'(117304);
            6:       v = ZW'(58665);
            7:       v = ZW'(29335);
            8:       v = ZW'(14668);
            9:       v = ZW'(7334);
            10:      v = ZW'(3667);
            11:      v = ZW'(1833);
            12:      v = ZW'(917);
            13:      v = ZW'(458);
            14:      v = ZW'(229);
            15:      v = ZW'(115);
            16:      v = ZW'(57);
            17:      v = ZW'(29);
            18:      v = ZW'(14);
            19:      v = ZW'(7);
            20:      v = ZW'(4);
            21:      v = ZW'(2);
            22:      v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/averaged_tilt_roll_angle_top.sv
// Averaged roll angle: one sample accepted per cycle, three axis lanes sum it.
// Results pass offset, pre-rotation, CORDIC step and rounding registers;
// windows may close back to back, one CORDIC stage per iteration sets the depth.
// Sample input stalls only when a closing sample meets a full angle pipeline.
// Reset (rst_n, async, active low) restores register defaults (16, 512, 512)
// and clears the sample counter, accumulators and pipeline valid flags.
module averaged_tilt_roll_angle_top
    import atr_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  sample_t               sample,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Built from atr_pkg, atr_lane and atr_merge
    logic [CNT_W-1:0] count_reg;
    logic [ZG_W-1:0]  zgy_reg;
    logic [ZG_W-1:0]  zgz_reg;
    logic [CNT_W-1:0] taken_reg;
    logic [CNT_W-1:0] taken_next;
    logic [CNT_W-1:0] taken_inc;
    logic [CNT_W-1:0] count_eff;
    logic             closing;
    logic             accept;
    logic             win_ready;
    window_t          win;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CNT_W'(16);
            zgy_reg   <= ZG_W'(512);
            zgz_reg   <= ZG_W'(512);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_idx_t'(cfg_index))
                REG_SAMPLE_COUNT: count_reg <= cfg_data[CNT_W-1:0];
                REG_ZERO_G_Y:     zgy_reg   <= cfg_data[ZG_W-1:0];
                REG_ZERO_G_Z:     zgz_reg   <= cfg_data[ZG_W-1:0];
                default:          ;
            endcase
        end
    end

    // Window length limited to 1..MAX_SAMPLES
    always_comb
    begin
        if (count_reg == '0)
        begin
            count_eff = CNT_W'(1);
        end
        else if (count_reg > CNT_W'(MAX_SAMPLES))
        begin
            count_eff = CNT_W'(MAX_SAMPLES);
        end
        else
        begin
            count_eff = count_reg;
        end
    end

    // Sample counter and window close
    assign taken_inc    = taken_reg + CNT_W'(1);
    assign closing      = taken_inc >= count_eff;
    assign sample_stall = closing && !win_ready;
    assign accept       = sample_valid && !sample_stall;

    always_comb
    begin
        taken_next = taken_reg;
        if (accept)
        begin
            taken_next = closing ? '0 : taken_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg <= '0;
        end
        else
        begin
            taken_reg <= taken_next;
        end
    end

    // Axis lanes
    atr_lane u_lane_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .adc     (sample.adc_x),
        .take    (accept),
        .flush   (closing),
        .sum_now (win.sum_x)
    );

    atr_lane u_lane_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .adc     (sample.adc_y),
        .take    (accept),
        .flush   (closing),
        .sum_now (win.sum_y)
    );

    atr_lane u_lane_z (
        .clk     (clk),
        .rst_n   (rst_n),
        .adc     (sample.adc_z),
        .take    (accept),
        .flush   (closing),
        .sum_now (win.sum_z)
    );

    assign win.n = taken_inc;

    // Offset removal, CORDIC and output register
    atr_merge #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_valid && closing),
        .in_ready  (win_ready),
        .win       (win),
        .zero_g_y  (zgy_reg),
        .zero_g_z  (zgz_reg),
        .out_valid (result_valid),
        .out_ready (!result_stall),
        .res       (result)
    );

endmodule

// File: hdl/atr_lane.sv
// One axis accumulator lane: adds each sample reading into a running sum.
// Depends on atr_pkg.
module atr_lane
    import atr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [ADC_BITS-1:0] adc,
    input  logic                take,
    input  logic                flush,
    output logic [SUM_W-1:0]    sum_now
);

    logic [SUM_W-1:0] acc_reg;
    logic [SUM_W-1:0] acc_next;

    // Sum including the reading on offer; wraps at SUM_W bits
    assign sum_now = acc_reg + SUM_W'(adc);

    always_comb
    begin
        acc_next = acc_reg;
        if (take)
        begin
            acc_next = flush ? '0 : sum_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

// File: hdl/atr_cordic_step.sv
// One registered vectoring CORDIC iteration with its own handshake.
// Depends on atr_pkg (pipe_t, atan_q16).
module atr_cordic_step
    import atr_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  pipe_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output pipe_t out_item
);

    localparam logic [ZW-1:0] ANGLE = atan_q16(STEP);

    logic          valid_reg;
    logic          valid_next;
    pipe_t         item_reg;
    pipe_t         item_next;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [ZW-1:0] zs;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // Rotate towards the x axis; special-case items pass unchanged
    always_comb
    begin
        xs        = in_item.x;
        ys        = in_item.y;
        zs        = in_item.z;
        dx        = ys >>> STEP;
        dy        = xs >>> STEP;
        item_next = in_item;
        if (!in_item.spec)
        begin
            if (ys > 0)
            begin
                item_next.x = xs + dx;
                item_next.y = ys - dy;
                item_next.z = zs + $signed(ANGLE);
            end
            else
            begin
                item_next.x = xs - dx;
                item_next.y = ys + dy;
                item_next.z = zs - $signed(ANGLE);
            end
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// File: hdl/atr_merge.sv
// Merging stage: zero-g offset removal, quadrant pre-rotation, CORDIC chain
// and rounding of the roll angle. Depends on atr_pkg and atr_cordic_step.
module atr_merge
    import atr_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  window_t         win,
    input  logic [ZG_W-1:0] zero_g_y,
    input  logic [ZG_W-1:0] zero_g_z,
    output logic            out_valid,
    input  logic            out_ready,
    output result_t         res
);

    localparam logic signed [ZW-1:0] LIM = ZW'(DEG180_Q7);

    // Offset stage
    logic                    off_valid_reg;
    logic                    off_ready;
    logic [SUM_W-1:0]        off_sx_reg;
    logic [SUM_W-1:0]        off_sy_reg;
    logic [SUM_W-1:0]        off_sz_reg;
    logic signed [OFS_W-1:0] ny_reg;
    logic signed [OFS_W-1:0] nz_reg;
    logic signed [OFS_W-1:0] ny_next;
    logic signed [OFS_W-1:0] nz_next;
    logic [CNT_W+ZG_W-1:0]   prod_y;
    logic [CNT_W+ZG_W-1:0]   prod_z;

    // Pre-rotation stage
    logic                    pre_valid_reg;
    logic                    pre_ready;
    pipe_t                   pre_reg;
    pipe_t                   pre_next;
    logic signed [CW-1:0]    xe;
    logic signed [CW-1:0]    ye;
    logic signed [CW-1:0]    x1;
    logic signed [CW-1:0]    y1;
    logic signed [ZW-1:0]    z1;

    // CORDIC chain links
    pipe_t                   link     [CORDIC_STEPS+1];
    logic                    link_vld [CORDIC_STEPS+1];
    logic                    link_rdy [CORDIC_STEPS+1];

    // Rounding stage
    logic                    res_valid_reg;
    logic                    rnd_ready;
    result_t                 res_reg;
    result_t                 res_next;
    logic signed [ZW-1:0]    zf;
    logic signed [ZW-1:0]    zr;

    // Backward ready chain
    assign rnd_ready = !res_valid_reg || out_ready;
    assign pre_ready = !pre_valid_reg || link_rdy[0];
    assign off_ready = !off_valid_reg || pre_ready;
    assign in_ready  = off_ready;

    // n times zero-g level taken off the Y and Z sums
    always_comb
    begin
        prod_y  = (CNT_W+ZG_W)'(win.n) * (CNT_W+ZG_W)'(zero_g_y);
        prod_z  = (CNT_W+ZG_W)'(win.n) * (CNT_W+ZG_W)'(zero_g_z);
        ny_next = $signed(OFS_W'(win.sum_y)) - $signed(OFS_W'(prod_y));
        nz_next = $signed(OFS_W'(win.sum_z)) - $signed(OFS_W'(prod_z));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_valid_reg <= 1'b0;
            pre_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (off_ready)
            begin
                off_valid_reg <= in_valid;
            end
            if (pre_ready)
            begin
                pre_valid_reg <= off_valid_reg;
            end
            if (rnd_ready)
            begin
                res_valid_reg <= link_vld[CORDIC_STEPS];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (off_ready && in_valid)
        begin
            off_sx_reg <= win.sum_x;
            off_sy_reg <= win.sum_y;
            off_sz_reg <= win.sum_z;
            ny_reg     <= ny_next;
            nz_reg     <= nz_next;
        end
        if (pre_ready && off_valid_reg)
        begin
            pre_reg <= pre_next;
        end
        if (rnd_ready && link_vld[CORDIC_STEPS])
        begin
            res_reg <= res_next;
        end
    end

    // Exact axes marked as special; left half-plane folded onto the right half-plane
    always_comb
    begin
        xe = CW'(nz_reg);
        ye = CW'(ny_reg);
        x1 = xe;
        y1 = ye;
        z1 = '0;
        if (nz_reg < 0)
        begin
            if (ny_reg > 0)
            begin
                x1 = ye;
                y1 = -xe;
                z1 = ZW'(DEG90_Q16);
            end
            else
            begin
                x1 = -ye;
                y1 = xe;
                z1 = -ZW'(DEG90_Q16);
            end
        end
        pre_next.sum_x    = off_sx_reg;
        pre_next.sum_y    = off_sy_reg;
        pre_next.sum_z    = off_sz_reg;
        pre_next.x        = x1 <<< PRE_SHIFT;
        pre_next.y        = y1 <<< PRE_SHIFT;
        pre_next.z        = z1;
        pre_next.spec     = 1'b0;
        pre_next.spec_ang = '0;
        if (ny_reg == 0)
        begin
            pre_next.spec     = 1'b1;
            pre_next.spec_ang = (nz_reg < 0) ? ANG_W'(DEG180_Q7) : '0;
        end
        else if (nz_reg == 0)
        begin
            pre_next.spec     = 1'b1;
            pre_next.spec_ang = (ny_reg > 0) ? ANG_W'(DEG90_Q7) : -ANG_W'(DEG90_Q7);
        end
    end

    assign link[0]     = pre_reg;
    assign link_vld[0] = pre_valid_reg;
    assign link_rdy[CORDIC_STEPS] = rnd_ready;

    // One registered iteration per step
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        atr_cordic_step #(
            .STEP (i)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (link_vld[i]),
            .in_ready  (link_rdy[i]),
            .in_item   (link[i]),
            .out_valid (link_vld[i+1]),
            .out_ready (link_rdy[i+1]),
            .out_item  (link[i+1])
        );
    end

    // Round half up from Q16 to Q7 and limit to +-180 degrees
    always_comb
    begin
        zf = link[CORDIC_STEPS].z;
        zr = (zf + ZW'(RND_BIAS)) >>> RND_SHIFT;
        if (zr > LIM)
        begin
            zr = LIM;
        end
        else if (zr < -LIM)
        begin
            zr = -LIM;
        end
        res_next.sum_x      = link[CORDIC_STEPS].sum_x;
        res_next.sum_y      = link[CORDIC_STEPS].sum_y;
        res_next.sum_z      = link[CORDIC_STEPS].sum_z;
        res_next.roll_angle = link[CORDIC_STEPS].spec ? link[CORDIC_STEPS].spec_ang
                                                      : zr[ANG_W-1:0];
    end

    assign out_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// File: dv/tb_averaged_tilt_roll_angle_top.sv
// Self-checking testbench for averaged_tilt_roll_angle_top: directed table, then random windows.
// Predicts the sums and the CORDIC roll angle per window and checks each result transfer.
// Depends on hdl/atr_pkg.sv and hdl/averaged_tilt_roll_angle_top.sv.
module tb_averaged_tilt_roll_angle_top;
    import atr_pkg::*;

    localparam int CORDIC_STEPS  = 16;
    localparam int PIPE_LATENCY  = CORDIC_STEPS + 3;
    localparam int RANDOM_ITEMS  = 1100;
    localparam int DRAIN_LIMIT   = 100000;
    localparam int TIMEOUT_UNITS = 400000;

    // Index with no register behind it; writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        sample_t                smp;
        logic [6:0]             reps;
        bit                     typed;
        result_t                want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  sample_valid = 1'b0;
    logic                  sample_stall;
    sample_t               sample = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    result_t               result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Predictor copy of the configuration and the window state
    logic [6:0]  pred_count;
    logic [9:0]  pred_zgy;
    logic [9:0]  pred_zgz;
    int          taken;
    logic [15:0] acc_x;
    logic [15:0] acc_y;
    logic [15:0] acc_z;

    // atan(2^-i) in degrees, 16 fraction bits
    longint atan_step_q16 [0:15] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                     58665, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                     229, 115};

    result_t   pending_windows [$];
    stim_row_t stim_table [$];
    result_t   head;

    int fails = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    averaged_tilt_roll_angle_top #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Roll angle in degrees * 128 from the offset-corrected Y and Z sums
    function automatic logic [15:0] tilt_angle_q7(input longint ny, input longint nz);
        longint x;
        longint y;
        longint z;
        longint t;
        longint dx;
        longint dy;
        longint r;
        x = nz;
        y = ny;
        z = 0;
        if (y == 0)
            return (x >= 0) ? 16'd0 : 16'(DEG180_Q7);
        if (x == 0)
            return (y > 0) ? 16'(DEG90_Q7) : 16'(-DEG90_Q7);
        // fold the left half-plane onto the right with a quarter turn
        if (x < 0)
        begin
            t = x;
            if (y > 0)
            begin
                x = y;
                y = -t;
                z = DEG90_Q16;
            end
            else
            begin
                x = -y;
                y = t;
                z = -DEG90_Q16;
            end
        end
        x = x * 256;
        y = y * 256;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + atan_step_q16[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - atan_step_q16[i];
            end
        end
        // round half up to 7 fraction bits, then limit to +-180 degrees
        r = (z + 256) >>> 9;
        if (r > DEG180_Q7)
            r = DEG180_Q7;
        if (r < -DEG180_Q7)
            r = -DEG180_Q7;
        return 16'(r);
    endfunction

    // Add one sample to the window; report the result if the window closes
    task automatic fold_sample(input sample_t s, output bit closed, output result_t r);
        int     limit;
        longint ny;
        longint nz;
        limit = int'(pred_count);
        if (limit < 1)
            limit = 1;
        if (limit > MAX_SAMPLES)
            limit = MAX_SAMPLES;
        acc_x = acc_x + 16'(s.adc_x);
        acc_y = acc_y + 16'(s.adc_y);
        acc_z = acc_z + 16'(s.adc_z);
        taken = taken + 1;
        closed = (taken >= limit);
        r = '0;
        if (closed)
        begin
            ny = longint'(acc_y) - longint'(taken) * longint'(pred_zgy);
            nz = longint'(acc_z) - longint'(taken) * longint'(pred_zgz);
            r.sum_x = acc_x;
            r.sum_y = acc_y;
            r.sum_z = acc_z;
            r.roll_angle = tilt_angle_q7(ny, nz);
            taken = 0;
            acc_x = '0;
            acc_y = '0;
            acc_z = '0;
        end
    endtask

    // Hold samples back until every window result has come and the pipe is empty
    task automatic wait_for_quiet();
        sample_valid <= 1'b0;
        while (pending_windows.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        wait_for_quiet();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SAMPLE_COUNT: pred_count = data[6:0];
            REG_ZERO_G_Y:     pred_zgy = data;
            REG_ZERO_G_Z:     pred_zgz = data;
            default:          ;
        endcase
    endtask

    // One sample transfer, with random idle cycles ahead of it
    task automatic send_sample(input sample_t s, input bit typed, input result_t want);
        bit      closed;
        result_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample <= s;
        do
            @(posedge clk);
        while (sample_stall);
        fold_sample(s, closed, r);
        if (closed)
            pending_windows.push_back(typed ? want : r);
    endtask

    task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        stim_row_t row;
        row = '0;
        row.kind = ROW_WRITE;
        row.idx = idx;
        row.data = data;
        stim_table.push_back(row);
    endtask

    task automatic add_sample(input int reps, input int x, input int y, input int z);
        stim_row_t row;
        row = '0;
        row.kind = ROW_SAMPLE;
        row.reps = 7'(reps);
        row.smp.adc_x = 10'(x);
        row.smp.adc_y = 10'(y);
        row.smp.adc_z = 10'(z);
        stim_table.push_back(row);
    endtask

    // Sample row whose closing result is written out by hand
    task automatic add_checked(input int reps, input int x, input int y, input int z,
                               input int sx, input int sy, input int sz, input int ang);
        add_sample(reps, x, y, z);
        stim_table[stim_table.size() - 1].typed = 1'b1;
        stim_table[stim_table.size() - 1].want = {16'(sx), 16'(sy), 16'(sz), 16'(ang)};
    endtask

    function automatic logic [9:0] near_level(input int level, input int spread);
        int v;
        v = level + int'($urandom_range(2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return v[9:0];
    endfunction

    function automatic logic [9:0] extreme_level();
        case ($urandom_range(2))
            0:       return 10'd0;
            1:       return 10'd1023;
            default: return 10'($urandom);
        endcase
    endfunction

    // Sample shapes: free noise, resting near zero g, steady tilt, rail values
    function automatic sample_t draw_sample(input int style, input bit y_on_axis,
                                            input bit z_on_axis, input int tilt_y,
                                            input int tilt_z);
        sample_t s;
        s.adc_x = 10'($urandom);
        case (style)
            0:
            begin
                s.adc_y = 10'($urandom);
                s.adc_z = 10'($urandom);
            end
            1:
            begin
                s.adc_y = y_on_axis ? pred_zgy : near_level(int'(pred_zgy), 4);
                s.adc_z = z_on_axis ? pred_zgz : near_level(int'(pred_zgz), 4);
            end
            2:
            begin
                s.adc_y = near_level(int'(pred_zgy) + tilt_y, 3);
                s.adc_z = near_level(int'(pred_zgz) + tilt_z, 3);
            end
            default:
            begin
                s.adc_x = extreme_level();
                s.adc_y = extreme_level();
                s.adc_z = extreme_level();
            end
        endcase
        return s;
    endfunction

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
        begin
            fails++;
            if (fails <= 10)
                $display("mismatch on %s: expected 0x%h, got 0x%h", name, want, got);
        end
    endtask

    // Result side: check each transfer against the oldest prediction, then stall at random
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_windows.size() == 0)
            begin
                fails++;
                if (fails <= 10)
                    $display("result with nothing expected: 0x%h", result);
            end
            else
            begin
                head = pending_windows.pop_front();
                check_field("sum_x", result.sum_x, head.sum_x);
                check_field("sum_y", result.sum_y, head.sum_y);
                check_field("sum_z", result.sum_z, head.sum_z);
                check_field("roll_angle", result.roll_angle, head.roll_angle);
            end
        end
        result_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial
    begin
        #(TIMEOUT_UNITS);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int         phase_items;
        int         eff;
        int         batch;
        int         style;
        int         tilt_y;
        int         tilt_z;
        int         spins;
        bit         y_on_axis;
        bit         z_on_axis;
        bit         first;
        logic [9:0] val;

        // predictor mirrors the reset state of the block
        pred_count = 7'd16;
        pred_zgy = 10'd512;
        pred_zgz = 10'd512;
        taken = 0;
        acc_x = '0;
        acc_y = '0;
        acc_z = '0;

        // Directed table: reset defaults, exact axes, zero-g extremes, count corner cases
        add_checked(16, 1023, 512, 1023, 16368, 8192, 16368, 0);
        add_write(REG_SAMPLE_COUNT, 10'd1);
        add_checked(1, 512, 512, 512, 512, 512, 512, 0);
        add_checked(1, 0, 512, 0, 0, 512, 0, DEG180_Q7);
        add_checked(1, 0, 1023, 512, 0, 1023, 512, DEG90_Q7);
        add_checked(1, 1023, 0, 512, 1023, 0, 512, -DEG90_Q7);
        add_sample(1, 682, 1023, 0);
        add_sample(1, 85, 513, 0);
        add_sample(1, 170, 511, 0);
        add_write(REG_ZERO_G_Y, 10'd0);
        add_write(REG_ZERO_G_Z, 10'd0);
        add_checked(1, 5, 0, 0, 5, 0, 0, 0);
        add_write(REG_ZERO_G_Y, 10'd1023);
        add_write(REG_ZERO_G_Z, 10'd1023);
        add_checked(1, 0, 1023, 0, 0, 1023, 0, DEG180_Q7);
        // count lowered while a window is open: closes on the next sample
        add_write(REG_SAMPLE_COUNT, 10'd2);
        add_sample(1, 512, 100, 900);
        add_write(REG_SAMPLE_COUNT, 10'd1);
        add_sample(1, 7, 900, 100);
        add_write(REG_SPARE, 10'h3FF);
        add_sample(1, 100, 200, 300);
        // zero count behaves as one
        add_write(REG_SAMPLE_COUNT, 10'd0);
        add_sample(1, 1, 2, 4);

        send_idle_pct = 30;
        recv_stall_pct = 76;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[k])
        begin
            if (stim_table[k].kind == ROW_WRITE)
                write_reg(stim_table[k].idx, stim_table[k].data);
            else
                repeat (int'(stim_table[k].reps))
                    send_sample(stim_table[k].smp, stim_table[k].typed, stim_table[k].want);
        end

        // Random windows over three idling regimes
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 30;
                    recv_stall_pct = 76;
                end
                1:
                begin
                    send_idle_pct = 76;
                    recv_stall_pct = 30;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            phase_items = 0;
            first = 1'b1;
            while (phase_items < RANDOM_ITEMS / 3)
            begin
                if (first || $urandom_range(9) < 7)
                begin
                    case ($urandom_range(9))
                        0:       val = 10'd0;
                        1:       val = 10'd1;
                        2:       val = 10'd64;
                        3:       val = {3'($urandom), 7'($urandom_range(127, 65))};
                        4:       val = {3'($urandom_range(7, 1)), 7'($urandom_range(8, 1))};
                        default: val = 10'($urandom_range(8, 2));
                    endcase
                    write_reg(REG_SAMPLE_COUNT, val);
                end
                if (first || $urandom_range(9) < 7)
                begin
                    case ($urandom_range(3))
                        0:       val = 10'd0;
                        1:       val = 10'd1023;
                        2:       val = 10'($urandom);
                        default: val = near_level(512, 40);
                    endcase
                    write_reg(REG_ZERO_G_Y, val);
                end
                if (first || $urandom_range(9) < 7)
                begin
                    case ($urandom_range(3))
                        0:       val = 10'd0;
                        1:       val = 10'd1023;
                        2:       val = 10'($urandom);
                        default: val = near_level(512, 40);
                    endcase
                    write_reg(REG_ZERO_G_Z, val);
                end
                if ($urandom_range(9) == 0)
                    write_reg(REG_SPARE, 10'($urandom));
                first = 1'b0;

                eff = int'(pred_count);
                if (eff < 1)
                    eff = 1;
                if (eff > MAX_SAMPLES)
                    eff = MAX_SAMPLES;
                style = $urandom_range(3);
                y_on_axis = $urandom_range(1);
                z_on_axis = $urandom_range(1);
                tilt_y = int'($urandom_range(1022)) - 511;
                tilt_z = int'($urandom_range(1022)) - 511;
                batch = eff * int'($urandom_range(3, 1)) + int'($urandom_range(eff));
                // keep the phase to its share of the items
                if (batch > RANDOM_ITEMS / 3 - phase_items)
                    batch = RANDOM_ITEMS / 3 - phase_items;
                repeat (batch)
                    send_sample(draw_sample(style, y_on_axis, z_on_axis, tilt_y, tilt_z),
                                1'b0, '0);
                phase_items += batch;
            end
        end

        // Drain: remaining results, then the pipeline depth
        sample_valid <= 1'b0;
        spins = 0;
        while (pending_windows.size() != 0 && spins < DRAIN_LIMIT)
        begin
            @(posedge clk);
            spins++;
        end
        repeat (PIPE_LATENCY + 4) @(posedge clk);
        if (pending_windows.size() != 0)
            fails++;

        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
